[rtl/core/hex_line_word_loader_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef HEX_LINE_WORD_LOADER_TOP_ASSERT_SVH
`define HEX_LINE_WORD_LOADER_TOP_ASSERT_SVH

// Clocked assertion, ignored while reset is asserted.
`define HLWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HLWL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/hlwl_pkg.sv]
package hlwl_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned AddrField  = 14;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned OutPayload = AddrField + WordWidth;
  localparam int unsigned OutTdataW  = ((OutPayload + 7) / 8) * 8;

  localparam logic [CharWidth-1:0]  CH_LF      = 8'h0A;
  localparam logic [CharWidth-1:0]  CH_CR      = 8'h0D;
  localparam logic [CountWidth-1:0] WORD_CHARS = 4'd8;
  localparam logic [WordWidth-1:0]  END_WORD   = 32'hFFFF_FFFF;

  // Hex digit value of an ASCII code, zero for anything else.
  function automatic logic [3:0] nibble_of(input logic [CharWidth-1:0] ch);
    logic [3:0] nib;
    nib = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      nib = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      nib = ch[3:0] + 4'd9;
    end
    return nib;
  endfunction

endpackage

[rtl/core/hex_line_word_loader_top.sv]
// Hex line word loader.
// Input stream (s_axis_*): one ASCII character per item in tdata[7:0].
// Up to eight characters per line are shifted in as hex nibbles, most
// significant first; non-hex characters count as zero and characters past
// the eighth are dropped. CR or LF ends the line. A line of eight or more
// characters produces one output item: a memory write at the running word
// address, which then advances and wraps at 2**ADDR_WIDTH words.
// Output stream (m_axis_*): tdata = {pad, mem_word, mem_addr}, tuser =
// end_marker, set when the word is all ones (that word is still written).
// Each character is registered on accept; a terminator that writes loads
// the result register, which drives m_axis. Throughput is one character
// per cycle while no write waits on a stalled receiver, set by the single
// character register feeding the line state and the result register.
// When the receiver stalls, the result register holds its item; characters
// that produce no write keep flowing, and a terminator that would write
// waits in the character register, after which s_axis_tready drops.
// Reset clears the character count, accumulator, address and both valids.
module hex_line_word_loader_top #(
  parameter int unsigned ADDR_WIDTH = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hlwl_pkg::CharWidth-1:0]    s_axis_tdata,   // [7:0] rx_char
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hlwl_pkg::OutTdataW-1:0]    m_axis_tdata,   // [13:0] mem_addr, [45:14] mem_word
  output logic                              m_axis_tuser    // [0] end_marker
);
  import hlwl_pkg::*;

  logic                  in_valid_q;
  logic [CharWidth-1:0]  in_char_q;
  logic [CountWidth-1:0] count_q, count_d;
  logic [WordWidth-1:0]  accum_q, accum_d;
  logic [ADDR_WIDTH-1:0] addr_q, addr_d;
  logic                  out_valid_q;
  logic [AddrField-1:0]  out_addr_q, addr_field;
  logic [WordWidth-1:0]  out_word_q;
  logic                  out_end_q;

  logic is_term, emits, out_free, advance;

  assign is_term  = (in_char_q == CH_LF) || (in_char_q == CH_CR);
  assign emits    = is_term && (count_q == WORD_CHARS);
  assign out_free = !out_valid_q || m_axis_tready;
  assign advance  = in_valid_q && (!emits || out_free);

  assign s_axis_tready = !in_valid_q || advance;

  generate
    if (ADDR_WIDTH >= AddrField) begin : g_addr_trunc
      assign addr_field = addr_q[AddrField-1:0];
    end else begin : g_addr_ext
      assign addr_field = {{(AddrField - ADDR_WIDTH){1'b0}}, addr_q};
    end
  endgenerate

  always_comb begin
    count_d = count_q;
    accum_d = accum_q;
    addr_d  = addr_q;
    if (advance) begin
      if (is_term) begin
        count_d = '0;
        accum_d = '0;
        if (emits) begin
          addr_d = addr_q + 1'b1;
        end
      end else if (count_q < WORD_CHARS) begin
        accum_d = {accum_q[WordWidth-5:0], nibble_of(in_char_q)};
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      accum_q     <= '0;
      addr_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance && emits) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      count_q <= count_d;
      accum_q <= accum_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
    end
    if (advance && emits) begin
      out_addr_q <= addr_field;
      out_word_q <= accum_q;
      out_end_q  <= (accum_q == END_WORD);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - OutPayload){1'b0}}, out_word_q, out_addr_q};
  assign m_axis_tuser  = out_end_q;

endmodule

[rtl/core/hlwl_checker.sv]
`include "hex_line_word_loader_top_assert.svh"

module hlwl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [hlwl_pkg::CharWidth-1:0] s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [hlwl_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import hlwl_pkg::*;

  logic               in_stall;
  logic               out_stall;
  logic [OutTdataW:0] out_frame;
  logic               out_is_end;
  logic               out_pad_zero;

  assign in_stall     = s_axis_tvalid && !s_axis_tready;
  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign out_frame    = {m_axis_tuser, m_axis_tdata};
  assign out_is_end   = (m_axis_tdata[OutPayload-1:AddrField] == END_WORD);
  assign out_pad_zero = (m_axis_tdata[OutTdataW-1:OutPayload] == '0);

  // A waiting input item stays put until taken.
  `HLWL_ASSERT(a_in_hold, in_stall |=> s_axis_tvalid && $stable(s_axis_tdata), "input not held")

  // A stalled result item keeps its payload.
  `HLWL_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_frame), "output not held")

  // End marker flags exactly the all-ones word.
  `HLWL_ASSERT(a_end_marker, m_axis_tvalid |-> m_axis_tuser == out_is_end, "end marker mismatch")

  // Padding bits of tdata stay zero.
  `HLWL_ASSERT_ALWAYS(a_pad_zero, m_axis_tvalid |-> out_pad_zero, "tdata padding not zero")

endmodule

bind hex_line_word_loader_top hlwl_checker u_hlwl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[test/tb_hex_line_word_loader_top.sv]
module tb_hex_line_word_loader_top;
  import hlwl_pkg::*;

  localparam int unsigned AW = 14;
  localparam int unsigned TotalChars = 650;
  localparam int unsigned SteadyLines = 20;
  localparam int unsigned IdlePct = 24;

  typedef struct packed {
    logic [AddrField-1:0] addr;
    logic [WordWidth-1:0] word;
    logic                 last_word;
  } mem_write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CharWidth-1:0]  s_axis_tdata = '0;   // [7:0] rx_char
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]  m_axis_tdata;        // [13:0] mem_addr, [45:14] mem_word
  logic                  m_axis_tuser;        // [0] end_marker

  hex_line_word_loader_top #(
    .ADDR_WIDTH(AW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // line decoder state
  logic [CountWidth-1:0] line_count = '0;
  logic [WordWidth-1:0]  line_word = '0;
  logic [AW-1:0]         next_addr = '0;

  mem_write_t pending_writes[$];

  bit          steady = 1'b0;      // no idling on either side while set
  int unsigned err_count = 0;
  int unsigned chars_sent = 0;
  int unsigned writes_seen = 0;
  int unsigned markers_seen = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout, %0d writes still pending", pending_writes.size());
    $display("** hex_line_word_loader_top: FAILED **");
    $finish;
  end

  task automatic report_err(input string msg);
    if (err_count < 20) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'("0" + n);
    return upper ? 8'("A" + n - 4'd10) : 8'("a" + n - 4'd10);
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  // Advance the line decoder by one accepted character.
  task automatic decode_char(input logic [7:0] c);
    mem_write_t w;
    if (c == CH_LF || c == CH_CR) begin
      if (line_count == WORD_CHARS) begin
        w.addr      = AddrField'(next_addr);
        w.word      = line_word;
        w.last_word = (line_word == END_WORD);
        pending_writes.push_back(w);
        next_addr = next_addr + 1'b1;
      end
      line_count = '0;
      line_word  = '0;
    end else if (line_count < WORD_CHARS) begin
      line_word  = {line_word[WordWidth-5:0], digit_value(c)};
      line_count = line_count + 1'b1;
    end
  endtask

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic feed_char(input logic [7:0] c);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
    decode_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      feed_char(s[i]);
    end
  endtask

  task automatic send_hex_line(input bit all_ones, input int unsigned noise_pct);
    for (int i = 0; i < 8; i++) begin
      if (!all_ones && $urandom_range(99) < noise_pct) begin
        feed_char(text_char());
      end else begin
        feed_char(hex_glyph(all_ones ? 4'hF : 4'($urandom_range(15)), $urandom_range(1)));
      end
    end
    feed_char($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    mem_write_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      writes_seen++;
      if (m_axis_tuser) markers_seen++;
      if (pending_writes.size() == 0) begin
        report_err($sformatf("unexpected write addr %0h word %08h",
                             m_axis_tdata[AddrField-1:0],
                             m_axis_tdata[AddrField +: WordWidth]));
      end else begin
        w = pending_writes.pop_front();
        if (m_axis_tdata[AddrField-1:0] !== w.addr) begin
          report_err($sformatf("mem_addr %0h, want %0h",
                               m_axis_tdata[AddrField-1:0], w.addr));
        end
        if (m_axis_tdata[AddrField +: WordWidth] !== w.word) begin
          report_err($sformatf("mem_word %08h, want %08h at addr %0h",
                               m_axis_tdata[AddrField +: WordWidth], w.word, w.addr));
        end
        if (m_axis_tuser !== w.last_word) begin
          report_err($sformatf("end_marker %b, want %b at addr %0h",
                               m_axis_tuser, w.last_word, w.addr));
        end
      end
    end
  end

  // Case mix, range edges, NUL/0xFF, end marker, CR then LF, short and long lines.
  task automatic test_directed();
    send_text("09afAF");
    feed_char(8'h00);
    feed_char(8'hFF);
    feed_char(CH_LF);
    send_text("FFFFFFFF");
    feed_char(CH_CR);
    feed_char(CH_LF);
    send_text("7");
    feed_char(CH_CR);
    send_text("`g@G/:Ee9");
    feed_char(CH_LF);
  endtask

  // Back-to-back lines with no idling on either side.
  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (SteadyLines) send_hex_line(1'b0, 0);
    steady = 1'b0;
  endtask

  task automatic test_random_lines();
    int unsigned pick;
    while (chars_sent < TotalChars) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_hex_line(1'b0, 5);
        if ($urandom_range(4) == 0) feed_char($urandom_range(1) ? CH_CR : CH_LF);
      end else if (pick < 70) begin
        send_hex_line(1'b1, 0);
      end else if (pick < 82) begin
        repeat ($urandom_range(7)) feed_char(text_char());
        feed_char($urandom_range(1) ? CH_CR : CH_LF);
      end else if (pick < 92) begin
        repeat ($urandom_range(14, 9)) begin
          if ($urandom_range(1)) feed_char(hex_glyph(4'($urandom_range(15)), $urandom_range(1)));
          else feed_char(text_char());
        end
        feed_char($urandom_range(1) ? CH_CR : CH_LF);
      end else begin
        // raw bytes, terminators included by chance
        repeat ($urandom_range(6, 1)) feed_char(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_back_to_back();
    test_random_lines();
    s_axis_tvalid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d characters, checked %0d writes (%0d end markers)",
             chars_sent, writes_seen, markers_seen);
    $display("directed, back-to-back and random lines, %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("** hex_line_word_loader_top: PASSED **");
    end else begin
      $display("** hex_line_word_loader_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/hlwl_pkg.sv
rtl/core/hex_line_word_loader_top.sv
rtl/core/hlwl_checker.sv
test/tb_hex_line_word_loader_top.sv
